/* sv/fractional_nonrestoring_divider_macros.svh */
// Assertion macros used by the fractional divider top level.
`ifndef FRACTIONAL_NONRESTORING_DIVIDER_MACROS_SVH
`define FRACTIONAL_NONRESTORING_DIVIDER_MACROS_SVH

// Same-cycle implication checked on every rising clock edge outside reset.
`define FND_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication checked on every rising clock edge outside reset.
`define FND_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

/* sv/fnd_pkg.sv */
// Shared types for the fractional non-restoring divider.
`timescale 1ns / 1ps

package fnd_pkg;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_DIV_ZERO     = 2'd1,
      STATUS_NOT_FRACTION = 2'd2
   } status_type;

endpackage

/* sv/fractional_nonrestoring_divider.sv */
// An accepted req_ beat passes through every step cell and then the output stage to rsp_valid.
// Throughput: one beat per cycle while rsp_ready is high; each cell of the chain holds one division.
// The chain has QUOTIENT_BITS-1 step cells and one correction/output stage.
// A stalled rsp_ beat backs up only the full cells; empty cells keep accepting.
// Reset clears the valid bit of every stage; data registers are not reset.
`timescale 1ns / 1ps
`include "fractional_nonrestoring_divider_macros.svh"

module fractional_nonrestoring_divider #(
   parameter int QUOTIENT_BITS = 8,
   parameter int OPERAND_BITS  = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [OPERAND_BITS-1:0]      req_numerator,
   input  logic [OPERAND_BITS-1:0]      req_divisor,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [QUOTIENT_BITS-1:0]     rsp_quotient,
   output logic [OPERAND_BITS-1:0]      rsp_remainder,
   output logic [1:0]                   rsp_status
);
   import fnd_pkg::*;

   localparam int PartBits = OPERAND_BITS + 2;
   localparam int Cells    = QUOTIENT_BITS - 1;

   logic                         valid_w   [Cells+1];
   logic                         ready_w   [Cells+1];
   logic signed [PartBits-1:0]   part_w    [Cells+1];
   logic [OPERAND_BITS-1:0]      divisor_w [Cells+1];
   logic [QUOTIENT_BITS-1:0]     quot_w    [Cells+1];
   status_type                   status_w  [Cells+1];
   logic signed [PartBits-1:0]   last_div;

   assign valid_w[0]   = req_valid;
   assign req_ready    = ready_w[0];
   assign part_w[0]    = $signed({1'b0, req_numerator, 1'b0}) - $signed({2'b00, req_divisor});
   assign divisor_w[0] = req_divisor;
   assign quot_w[0]    = '0;

   always_comb begin
      if (req_divisor == '0) begin
         status_w[0] = STATUS_DIV_ZERO;
      end else if (req_numerator >= req_divisor) begin
         status_w[0] = STATUS_NOT_FRACTION;
      end else begin
         status_w[0] = STATUS_OK;
      end
   end

   for (genvar i = 0; i < Cells; i++) begin : g_cell
      fnd_cell #(
         .OPERAND_BITS  (OPERAND_BITS),
         .QUOTIENT_BITS (QUOTIENT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (valid_w[i]),
         .up_ready   (ready_w[i]),
         .up_part    (part_w[i]),
         .up_divisor (divisor_w[i]),
         .up_quot    (quot_w[i]),
         .up_status  (status_w[i]),
         .dn_valid   (valid_w[i+1]),
         .dn_ready   (ready_w[i+1]),
         .dn_part    (part_w[i+1]),
         .dn_divisor (divisor_w[i+1]),
         .dn_quot    (quot_w[i+1]),
         .dn_status  (status_w[i+1])
      );
   end

   fnd_fix #(
      .OPERAND_BITS  (OPERAND_BITS),
      .QUOTIENT_BITS (QUOTIENT_BITS)
   ) u_fix (
      .clock         (clock),
      .reset         (reset),
      .up_valid      (valid_w[Cells]),
      .up_ready      (ready_w[Cells]),
      .up_part       (part_w[Cells]),
      .up_divisor    (divisor_w[Cells]),
      .up_quot       (quot_w[Cells]),
      .up_status     (status_w[Cells]),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_quotient  (rsp_quotient),
      .rsp_remainder (rsp_remainder),
      .rsp_status    (rsp_status)
   );

   assign last_div = $signed({2'b00, divisor_w[Cells]});

   // An empty output stage lets every cell pass its beat on.
   `FND_ASSERT_NOW(a_empty_accepts, clock, reset, !rsp_valid, req_ready)
   `FND_ASSERT_NOW(a_error_zeroed, clock, reset, rsp_valid && (rsp_status != STATUS_OK),
      (rsp_quotient == '0) && (rsp_remainder == '0))
   // The partial remainder entering the correction stays within one divisor of zero.
   `FND_ASSERT_NOW(a_part_bound, clock, reset,
      valid_w[Cells] && (status_w[Cells] == STATUS_OK),
      (part_w[Cells] < last_div) && (part_w[Cells] >= -last_div))
   `FND_ASSERT_NEXT(a_first_cell_loads, clock, reset, req_valid && req_ready, valid_w[1])

endmodule

/* sv/fnd_cell.sv */
// One add-or-subtract step of the divider chain with its own beat register.
`timescale 1ns / 1ps

module fnd_cell #(
   parameter int OPERAND_BITS  = 15,
   parameter int QUOTIENT_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                up_valid,
   output logic                                up_ready,
   input  logic signed [OPERAND_BITS+1:0]      up_part,
   input  logic        [OPERAND_BITS-1:0]      up_divisor,
   input  logic        [QUOTIENT_BITS-1:0]     up_quot,
   input  fnd_pkg::status_type                 up_status,
   output logic                                dn_valid,
   input  logic                                dn_ready,
   output logic signed [OPERAND_BITS+1:0]      dn_part,
   output logic        [OPERAND_BITS-1:0]      dn_divisor,
   output logic        [QUOTIENT_BITS-1:0]     dn_quot,
   output fnd_pkg::status_type                 dn_status
);
   import fnd_pkg::*;

   localparam int PartBits = OPERAND_BITS + 2;

   logic                         valid_ff;
   logic signed [PartBits-1:0]   part_ff, part_in;
   logic [OPERAND_BITS-1:0]      divisor_ff;
   logic [QUOTIENT_BITS-1:0]     quot_ff, quot_in;
   status_type                   status_ff;
   logic signed [PartBits-1:0]   div_ext;
   logic                         load;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign div_ext  = $signed({2'b00, up_divisor});

   always_comb begin
      if (up_part[PartBits-1]) begin
         part_in = (up_part <<< 1) + div_ext;
      end else begin
         part_in = (up_part <<< 1) - div_ext;
      end
      quot_in = {up_quot[QUOTIENT_BITS-2:0], ~up_part[PartBits-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         part_ff    <= part_in;
         divisor_ff <= up_divisor;
         quot_ff    <= quot_in;
         status_ff  <= up_status;
      end
   end

   assign dn_valid   = valid_ff;
   assign dn_part    = part_ff;
   assign dn_divisor = divisor_ff;
   assign dn_quot    = quot_ff;
   assign dn_status  = status_ff;

endmodule

/* sv/fnd_fix.sv */
// Last quotient bit, remainder correction and the result register.
`timescale 1ns / 1ps

module fnd_fix #(
   parameter int OPERAND_BITS  = 15,
   parameter int QUOTIENT_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                up_valid,
   output logic                                up_ready,
   input  logic signed [OPERAND_BITS+1:0]      up_part,
   input  logic        [OPERAND_BITS-1:0]      up_divisor,
   input  logic        [QUOTIENT_BITS-1:0]     up_quot,
   input  fnd_pkg::status_type                 up_status,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [QUOTIENT_BITS-1:0]     rsp_quotient,
   output logic        [OPERAND_BITS-1:0]      rsp_remainder,
   output logic        [1:0]                   rsp_status
);
   import fnd_pkg::*;

   localparam int PartBits = OPERAND_BITS + 2;

   logic                         valid_ff;
   logic [QUOTIENT_BITS-1:0]     quot_ff, quot_in;
   logic [OPERAND_BITS-1:0]      rem_ff, rem_in;
   status_type                   status_ff;
   logic signed [PartBits-1:0]   fixed_part;
   logic                         load;

   assign up_ready = !valid_ff || rsp_ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      if (up_part[PartBits-1]) begin
         fixed_part = up_part + $signed({2'b00, up_divisor});
      end else begin
         fixed_part = up_part;
      end
      if (up_status == STATUS_OK) begin
         quot_in = {up_quot[QUOTIENT_BITS-2:0], ~up_part[PartBits-1]};
         rem_in  = fixed_part[OPERAND_BITS-1:0];
      end else begin
         quot_in = '0;
         rem_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         quot_ff   <= quot_in;
         rem_ff    <= rem_in;
         status_ff <= up_status;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_quotient  = quot_ff;
   assign rsp_remainder = rem_ff;
   assign rsp_status    = status_ff;

endmodule

/* test/tb_fractional_nonrestoring_divider.sv */
// Self-checking testbench for the fractional non-restoring divider.
`timescale 1ns / 1ps

module tb_fractional_nonrestoring_divider;
   import fnd_pkg::*;

   localparam int QUOTIENT_BITS = 8;
   localparam int OPERAND_BITS  = 15;
   localparam int RANDOM_PAIRS  = 1000;
   localparam int SETTLE_CYCLES = 3 * QUOTIENT_BITS + 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic [OPERAND_BITS-1:0] numerator;
      logic [OPERAND_BITS-1:0] divisor;
      int                      phase;
      bit                      drain;
   } operand_pair_type;

   typedef struct {
      logic [QUOTIENT_BITS-1:0] quotient;
      logic [OPERAND_BITS-1:0]  remainder;
      status_type               status;
   } division_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [OPERAND_BITS-1:0]  req_numerator = '0;
   logic [OPERAND_BITS-1:0]  req_divisor = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [QUOTIENT_BITS-1:0] rsp_quotient;
   logic [OPERAND_BITS-1:0]  rsp_remainder;
   logic [1:0]               rsp_status;

   operand_pair_type    pending_pairs[$];
   division_result_type expected_results[$];
   int                  traffic_phase = 0;
   int                  mismatch_count = 0;
   int                  cycle_count = 0;

   fractional_nonrestoring_divider #(
      .QUOTIENT_BITS(QUOTIENT_BITS),
      .OPERAND_BITS (OPERAND_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_numerator(req_numerator),
      .req_divisor  (req_divisor),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_quotient (rsp_quotient),
      .rsp_remainder(rsp_remainder),
      .rsp_status   (rsp_status)
   );

   always #4 clock = ~clock;

   function automatic division_result_type predict_division(
      input logic [OPERAND_BITS-1:0] numerator,
      input logic [OPERAND_BITS-1:0] divisor
   );
      division_result_type res;
      logic [31:0]         scaled;
      logic [31:0]         quot;
      res.quotient  = '0;
      res.remainder = '0;
      if (divisor == '0) begin
         res.status = STATUS_DIV_ZERO;
      end else if (numerator >= divisor) begin
         res.status = STATUS_NOT_FRACTION;
      end else begin
         scaled        = 32'(numerator) << QUOTIENT_BITS;
         quot          = scaled / 32'(divisor);
         res.quotient  = quot[QUOTIENT_BITS-1:0];
         res.remainder = OPERAND_BITS'(scaled - quot * 32'(divisor));
         res.status    = STATUS_OK;
      end
      return res;
   endfunction

   function automatic int sender_idle_pct(input int phase);
      return (phase == 0) ? 28 : (phase == 1) ? 55 : 0;
   endfunction

   function automatic int receiver_idle_pct(input int phase);
      return (phase == 0) ? 55 : (phase == 1) ? 28 : 0;
   endfunction

   task automatic queue_pair(input logic [OPERAND_BITS-1:0] numerator,
                             input logic [OPERAND_BITS-1:0] divisor,
                             input int phase, input bit drain);
      operand_pair_type pair;
      pair.numerator = numerator;
      pair.divisor   = divisor;
      pair.phase     = phase;
      pair.drain     = drain;
      pending_pairs.push_back(pair);
   endtask

   // Driver: presents one beat at a time and records the prediction on acceptance.
   always @(posedge clock) begin
      operand_pair_type pair;
      bit               holding;
      if (reset) begin
         req_valid     <= 1'b0;
         req_numerator <= '0;
         req_divisor   <= '0;
      end else begin
         holding = req_valid;
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_division(req_numerator, req_divisor));
            holding = 1'b0;
         end
         if (!holding) begin
            if (pending_pairs.size() > 0 &&
                !(pending_pairs[0].drain && expected_results.size() != 0) &&
                $urandom_range(99) >= sender_idle_pct(pending_pairs[0].phase)) begin
               pair = pending_pairs.pop_front();
               req_valid     <= 1'b1;
               req_numerator <= pair.numerator;
               req_divisor   <= pair.divisor;
               traffic_phase <= pair.phase;
            end else begin
               req_valid     <= 1'b0;
               req_numerator <= OPERAND_BITS'($urandom);
               req_divisor   <= OPERAND_BITS'($urandom);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct(traffic_phase));
      end
   end

   // Monitor: compares every accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      division_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < REPORT_LIMIT) begin
               $display("Unexpected result beat: q=%0d r=%0d status=%0d",
                        rsp_quotient, rsp_remainder, rsp_status);
            end
         end else begin
            want = expected_results.pop_front();
            if (rsp_quotient !== want.quotient || rsp_remainder !== want.remainder ||
                rsp_status !== want.status) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < REPORT_LIMIT) begin
                  $display({"Mismatch: expected q=%0d r=%0d status=%0d, ",
                            "got q=%0d r=%0d status=%0d"},
                           want.quotient, want.remainder, want.status,
                           rsp_quotient, rsp_remainder, rsp_status);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int                      phase;
      int                      kind;
      int                      width;
      logic [OPERAND_BITS-1:0] num;
      logic [OPERAND_BITS-1:0] div;

      // Directed beats: zero divisor, non-fractions, zero numerator and the extremes.
      queue_pair(15'd0, 15'd0, 0, 1'b0);
      queue_pair(15'h7fff, 15'd0, 0, 1'b0);
      queue_pair(15'h2aaa, 15'd0, 0, 1'b0);
      queue_pair(15'd0, 15'd1, 0, 1'b0);
      queue_pair(15'd0, 15'h7fff, 0, 1'b0);
      queue_pair(15'd1, 15'd2, 0, 1'b0);
      queue_pair(15'd1, 15'd3, 0, 1'b0);
      queue_pair(15'd2, 15'd3, 0, 1'b0);
      queue_pair(15'd1, 15'h7fff, 0, 1'b0);
      queue_pair(15'h7ffe, 15'h7fff, 0, 1'b0);
      queue_pair(15'h7fff, 15'h7fff, 0, 1'b0);
      queue_pair(15'd5, 15'd5, 0, 1'b0);
      queue_pair(15'h7fff, 15'd1, 0, 1'b0);
      queue_pair(15'd3, 15'd2, 0, 1'b0);
      queue_pair(15'd100, 15'd257, 0, 1'b0);
      queue_pair(15'd12345, 15'd23456, 0, 1'b0);
      queue_pair(15'h2aaa, 15'h5555, 0, 1'b0);
      queue_pair(15'h5555, 15'h7fff, 0, 1'b0);
      queue_pair(15'h4000, 15'h4001, 0, 1'b0);
      queue_pair(15'h3fff, 15'h4000, 0, 1'b0);
      queue_pair(15'd127, 15'd128, 0, 1'b0);

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         phase = (i * 3) / RANDOM_PAIRS;
         kind  = $urandom_range(99);
         if (kind < 80) begin
            width = $urandom_range(OPERAND_BITS, 1);
            div   = OPERAND_BITS'($urandom_range((1 << width) - 1, 1 << (width - 1)));
            num   = OPERAND_BITS'($urandom_range(div - 1, 0));
         end else if (kind < 90) begin
            num = OPERAND_BITS'($urandom);
            div = OPERAND_BITS'($urandom_range(num, 1));
            if (num == '0) num = div;
         end else if (kind < 95) begin
            num = OPERAND_BITS'($urandom);
            div = '0;
         end else begin
            num = OPERAND_BITS'($urandom);
            div = OPERAND_BITS'($urandom);
         end
         queue_pair(num, div, phase,
                    (i == RANDOM_PAIRS / 3) || (i == 2 * RANDOM_PAIRS / 3) || (i == 500));
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (pending_pairs.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* fractional_nonrestoring_divider.f */
+incdir+sv
sv/fnd_pkg.sv
sv/fnd_cell.sv
sv/fnd_fix.sv
sv/fractional_nonrestoring_divider.sv
test/tb_fractional_nonrestoring_divider.sv
